/* design/mqts_pkg.sv */
// shared types and constants for the max queue built from two stacks
`default_nettype none
package mqts_pkg;

  localparam int DATA_W = 32;
  localparam int OUT_TDATA_W = 72;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  typedef struct packed {
    logic start;
    logic xfer_rd;
    logic xfer_wr;
    logic pop;
    logic cap_deq;
    logic cap_rmax;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic left_empty;
    logic right_empty;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

/* design/mqts_ctrl.sv */
// controller state machine for the max queue built from two stacks
`default_nettype none
module mqts_ctrl
  import mqts_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    s_tvalid,
  input  wire logic    s_tuser,
  output logic         s_tready,
  input  wire status_t status,
  output cmd_t         cmd
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_XFER_RD  = 3'd1;
  localparam logic [2:0] ST_XFER_WR  = 3'd2;
  localparam logic [2:0] ST_POP      = 3'd3;
  localparam logic [2:0] ST_DEQ_WAIT = 3'd4;
  localparam logic [2:0] ST_DEQ_MAX  = 3'd5;
  localparam logic [2:0] ST_FIN      = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.start = 1'b1;
          if (s_tuser == OP_ENQ || status.empty) begin
            state_next = ST_FIN;
          end else if (status.right_empty) begin
            state_next = ST_XFER_RD;
          end else begin
            state_next = ST_DEQ_WAIT;
          end
        end
      end
      ST_XFER_RD: begin
        cmd.xfer_rd = 1'b1;
        state_next = ST_XFER_WR;
      end
      ST_XFER_WR: begin
        cmd.xfer_wr = 1'b1;
        state_next = status.left_empty ? ST_POP : ST_XFER_RD;
      end
      ST_POP: begin
        cmd.pop = 1'b1;
        state_next = ST_DEQ_WAIT;
      end
      ST_DEQ_WAIT: begin
        cmd.cap_deq = 1'b1;
        state_next = status.right_empty ? ST_FIN : ST_DEQ_MAX;
      end
      ST_DEQ_MAX: begin
        cmd.cap_rmax = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

/* design/mqts_datapath.sv */
// datapath of the max queue: shared stack memory, stack pointers, maxima, result register
`default_nettype none
module mqts_datapath
  import mqts_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire cmd_t                    cmd,
  output status_t                      status,
  input  wire logic                    s_tuser,
  input  wire logic [DATA_W-1:0]       s_tdata,
  output logic                         m_tvalid,
  input  wire logic                    m_tready,
  output logic [OUT_TDATA_W-1:0]       m_tdata
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [2*DATA_W-1:0] mem [CAPACITY];

  logic [CW-1:0] lt;
  logic [CW-1:0] rc;
  logic signed [DATA_W-1:0] lmax;
  logic signed [DATA_W-1:0] rmax;
  logic signed [DATA_W-1:0] rd_val;
  logic signed [DATA_W-1:0] rd_max;
  logic signed [DATA_W-1:0] deq;
  logic under;
  logic over;

  logic signed [DATA_W-1:0] x;
  logic signed [DATA_W-1:0] lmax_new;
  logic signed [DATA_W-1:0] rmax_new;
  logic signed [DATA_W-1:0] largest;
  logic full;
  logic le;
  logic re;
  logic enq_now;
  logic pop_now;
  logic rd_en;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] top_addr;
  logic wr_en;
  logic [AW-1:0] wr_addr;
  logic [2*DATA_W-1:0] wr_data;

  assign x = s_tdata;
  assign le = (lt == '0);
  assign re = (rc == '0);
  assign full = (({1'b0, lt} + {1'b0, rc}) >= (CW + 1)'(CAPACITY));
  assign top_addr = AW'(CW'(CAPACITY) - rc);

  assign lmax_new = (le || x > lmax) ? x : lmax;
  assign rmax_new = (re || rd_val > rmax) ? rd_val : rmax;

  assign enq_now = cmd.start && (s_tuser == OP_ENQ) && !full;
  assign pop_now = cmd.pop || (cmd.start && (s_tuser == OP_DEQ) && !re);

  assign rd_en = pop_now || cmd.xfer_rd || (cmd.cap_deq && !re);
  assign rd_addr = cmd.xfer_rd ? AW'(lt - CW'(1)) : top_addr;

  assign wr_en = enq_now || cmd.xfer_wr;
  assign wr_addr = cmd.xfer_wr ? AW'(CW'(CAPACITY - 1) - rc) : AW'(lt);
  assign wr_data = cmd.xfer_wr ? {rmax_new, rd_val} : {lmax_new, x};

  always_comb begin
    if (le && re) begin
      largest = '0;
    end else if (re) begin
      largest = lmax;
    end else if (le) begin
      largest = rmax;
    end else begin
      largest = (lmax > rmax) ? lmax : rmax;
    end
  end

  assign status.empty = le && re;
  assign status.left_empty = le;
  assign status.right_empty = re;
  assign status.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      {rd_max, rd_val} <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lt <= '0;
      rc <= '0;
    end else begin
      if (enq_now) begin
        lt <= lt + CW'(1);
      end else if (cmd.xfer_rd) begin
        lt <= lt - CW'(1);
      end
      if (pop_now) begin
        rc <= rc - CW'(1);
      end else if (cmd.xfer_wr) begin
        rc <= rc + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enq_now) begin
      lmax <= lmax_new;
    end
    if (cmd.xfer_wr) begin
      rmax <= rmax_new;
    end else if (cmd.cap_rmax) begin
      rmax <= rd_max;
    end
    if (cmd.start) begin
      deq <= '0;
      under <= (s_tuser == OP_DEQ) && le && re;
      over <= (s_tuser == OP_ENQ) && full;
    end else if (cmd.cap_deq) begin
      deq <= rd_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {5'b0, over, under, (le && re), largest, deq};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, lt} + {1'b0, rc}) <= (CW + 1)'(CAPACITY))
    else $error("stack counts exceed capacity");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[2*DATA_W+1] && m_tdata[2*DATA_W+2]))
    else $error("underflow and overflow in one item");

  a_under_empty: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2*DATA_W+1]) |-> m_tdata[2*DATA_W])
    else $error("underflow item does not report empty");

  a_xfer_moves: assert property (@(posedge clk) disable iff (rst)
    cmd.xfer_wr |=> (rc == $past(rc) + CW'(1)))
    else $error("transfer write did not grow right stack");

  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("result loaded over a waiting item");

endmodule
`default_nettype wire

/* design/max_queue_two_stacks_unit.sv */
// top level of the max queue built from two stacks in one memory
// FIFO of signed 32-bit values that also reports the largest value held. One item is taken
// at a time. An enqueue, an underflow or an overflow passes from acceptance through the finish
// state to the result register. A dequeue whose right stack holds values reads the value and,
// unless it removed the last right-side value, the new top maximum, both through the
// registered read of the stack memory. A dequeue that finds the right stack empty first moves
// the left stack across one value at a time (memory read, then write). Every value crosses
// once. The last step waits for the result register to free up. The next item is accepted
// while a result waits on the master side.
`default_nettype none
module max_queue_two_stacks_unit
  import mqts_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [DATA_W-1:0]      s_tdata,  // value
  input  wire logic                   s_tuser,  // opcode
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_TDATA_W-1:0]      m_tdata   // dequeued, largest, is_empty, underflow, overflow
);

  cmd_t    cmd;
  status_t status;

  mqts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mqts_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
`default_nettype wire

/* tb/mqts_checker.sv */
// checker for the max queue: predicts every result from the accepted items and compares
`default_nettype none
module mqts_checker
  import mqts_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  input  wire logic                   s_tready,
  input  wire logic [DATA_W-1:0]      s_tdata,  // value
  input  wire logic                   s_tuser,  // opcode
  input  wire logic                   m_tvalid,
  input  wire logic                   m_tready,
  input  wire logic [OUT_TDATA_W-1:0] m_tdata,  // dequeued, largest, is_empty, underflow, overflow
  output int                          errors,
  output int                          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DATA_W-1:0] dequeued;
    logic [DATA_W-1:0] largest;
    logic              is_empty;
    logic              underflow;
    logic              overflow;
  } outcome_t;

  // two stacks in one store, left grows up from 0, right grows down from the top
  logic signed [DATA_W-1:0] vals [CAPACITY];
  logic signed [DATA_W-1:0] maxs [CAPACITY];
  int left_cnt;
  int right_idx;
  outcome_t expected_q[$];

  function automatic outcome_t queue_step(logic op, logic signed [DATA_W-1:0] x);
    outcome_t r;
    logic signed [DATA_W-1:0] moved;
    logic signed [DATA_W-1:0] lmax;
    logic signed [DATA_W-1:0] rmax;
    logic l_empty;
    logic r_empty;
    r = '0;
    if (op == OP_ENQ) begin
      if (left_cnt > right_idx) begin
        r.overflow = 1'b1;
      end else begin
        vals[left_cnt] = x;
        if (left_cnt == 0 || x > maxs[left_cnt-1]) maxs[left_cnt] = x;
        else maxs[left_cnt] = maxs[left_cnt-1];
        left_cnt++;
      end
    end else if (left_cnt == 0 && right_idx == CAPACITY-1) begin
      r.underflow = 1'b1;
    end else begin
      // right stack empty: move the left stack over, oldest ends on top
      if (right_idx == CAPACITY-1) begin
        while (left_cnt > 0) begin
          left_cnt--;
          moved = vals[left_cnt];
          vals[right_idx] = moved;
          if (right_idx == CAPACITY-1 || moved > maxs[right_idx+1]) maxs[right_idx] = moved;
          else maxs[right_idx] = maxs[right_idx+1];
          right_idx--;
        end
      end
      right_idx++;
      r.dequeued = vals[right_idx];
    end
    l_empty = (left_cnt == 0);
    r_empty = (right_idx == CAPACITY-1);
    r.is_empty = l_empty && r_empty;
    lmax = l_empty ? '0 : maxs[left_cnt-1];
    rmax = r_empty ? '0 : maxs[right_idx+1];
    if (l_empty && r_empty) r.largest = '0;
    else if (r_empty) r.largest = lmax;
    else if (l_empty) r.largest = rmax;
    else r.largest = (lmax > rmax) ? lmax : rmax;
    return r;
  endfunction

  function automatic int field_bad(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    int bad;
    bad = 0;
    if (rst) begin
      left_cnt = 0;
      right_idx = CAPACITY - 1;
      expected_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
          bad = 1;
        end else begin
          want = expected_q.pop_front();
          bad += field_bad("dequeued", want.dequeued, m_tdata[31:0]);
          bad += field_bad("largest", want.largest, m_tdata[63:32]);
          bad += field_bad("is_empty", 32'(want.is_empty), 32'(m_tdata[64]));
          bad += field_bad("underflow", 32'(want.underflow), 32'(m_tdata[65]));
          bad += field_bad("overflow", 32'(want.overflow), 32'(m_tdata[66]));
        end
      end
      if (s_tvalid && s_tready) expected_q.push_back(queue_step(s_tuser, s_tdata));
    end
    errors <= errors + bad;
    outstanding <= expected_q.size();
  end

endmodule
`default_nettype wire

/* tb/tb.sv */
// testbench top for the max queue: drives items and back-pressure, gives the verdict
`default_nettype none
module tb
  import mqts_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY = 1024;
  localparam int LIMIT_CYCLES = 400000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [DATA_W-1:0]      s_tdata = '0;  // value
  logic                   s_tuser = OP_ENQ;  // opcode
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;  // dequeued, largest, is_empty, underflow, overflow
  int                     fail_count;
  int                     pending;
  int                     cycles = 0;
  bit                     gaps_on = 1'b1;
  int                     held = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  max_queue_two_stacks_unit #(.CAPACITY(CAPACITY)) u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  mqts_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .errors(fail_count), .outstanding(pending)
  );

  always @(posedge clk) begin
    m_tready <= gaps_on ? ($urandom_range(99) >= 37) : 1'b1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("tb: errors");
      $finish;
    end
  end

  // extremes, small values for ties, or anything
  function automatic logic [DATA_W-1:0] rand_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return '1;
      4, 5: return DATA_W'($signed($urandom_range(15)) - 8);
      default: return $urandom();
    endcase
  endfunction

  task automatic send_item(input logic op, input logic [DATA_W-1:0] val);
    while (gaps_on && $urandom_range(99) < 37) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= val;
    do @(posedge clk); while (!s_tready);
    if (op == OP_ENQ && held < CAPACITY) held++;
    else if (op == OP_DEQ && held > 0) held--;
  endtask

  task automatic random_mix(input int n, input int enq_pct);
    repeat (n) begin
      send_item(($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ, rand_value());
    end
  endtask

  // enqueue until full, then a few more that must overflow
  task automatic fill_up(input int extra);
    while (held < CAPACITY) send_item(OP_ENQ, rand_value());
    repeat (extra) send_item(OP_ENQ, rand_value());
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed part
    send_item(OP_DEQ, $urandom());
    send_item(OP_ENQ, 32'h7fff_ffff);
    send_item(OP_ENQ, 32'h8000_0000);
    send_item(OP_ENQ, '0);
    send_item(OP_ENQ, '1);
    send_item(OP_ENQ, 32'd5);
    send_item(OP_ENQ, 32'd5);
    repeat (3) send_item(OP_DEQ, '1);
    send_item(OP_ENQ, -32'sd7);
    send_item(OP_ENQ, 32'h7fff_ffff);
    repeat (5) send_item(OP_DEQ, $urandom());
    send_item(OP_DEQ, '0);
    send_item(OP_ENQ, 32'h8000_0000);
    send_item(OP_DEQ, 32'h8000_0000);

    // random part
    random_mix(15, 50);
    gaps_on = 1'b0;
    random_mix(20, 60);
    while (held > 0) send_item(OP_DEQ, $urandom());
    // long stretch with no idling while the left stack grows
    while (held < 300) send_item(OP_ENQ, rand_value());
    gaps_on = 1'b1;
    fill_up(3);
    wait_drained();
    // the first of these moves the whole full left stack across
    repeat (5) send_item(OP_DEQ, $urandom());

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* max_queue_two_stacks_unit.f */
design/mqts_pkg.sv
design/mqts_ctrl.sv
design/mqts_datapath.sv
design/max_queue_two_stacks_unit.sv
tb/mqts_checker.sv
tb/tb.sv
